### design/bit_matrix_transitive_closure_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the transitive closure block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BIT_MATRIX_TRANSITIVE_CLOSURE_MACROS_SVH
`define BIT_MATRIX_TRANSITIVE_CLOSURE_MACROS_SVH

// Same-cycle implication
`define BMTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bmtc: same-cycle implication violated");

// Next-cycle implication
`define BMTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bmtc: next-cycle implication violated");

`endif

### design/bmtc_pkg.sv
// ----------------------------------------------------------------------------
// bmtc_pkg
// Shared constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bmtc_pkg;

  // Default graph size and fixed row width
  localparam int MAX_NODES_DEF = 32;
  localparam int ROW_W         = 32;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // write the incoming word into the row store
    logic step;       // run one Warshall step on pivot row idx
    logic clr_chg;    // start a new pass: clear the change flag
    logic emit;       // copy row idx into the output register
    logic emit_last;  // that row is the last node
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic pass_dirty; // some row changed in this pass so far (incl. this step)
    logic out_free;   // output register can take a word this cycle
  } status_t;

endpackage

### design/bmtc_ctrl.sv
// ----------------------------------------------------------------------------
// bmtc_ctrl
// Sequencer: load rows, repeat closure passes until stable, emit rows.
// ----------------------------------------------------------------------------
module bmtc_ctrl #(
  parameter int MAX_NODES = bmtc_pkg::MAX_NODES_DEF,
  parameter int IW        = $clog2(MAX_NODES),
  parameter int CW        = $clog2(MAX_NODES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tlast,
  output logic              in_tready,
  input  bmtc_pkg::status_t status,
  output bmtc_pkg::cmd_t    cmd,
  output logic [IW-1:0]     idx,
  output logic [CW-1:0]     count
);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PASS,
    ST_EMIT
  } state_t;

  state_t        state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          at_last;
  logic          room;

  // Current index is the final node of the graph
  assign at_last = ((CW'(idx_r) + CW'(1)) == count_r);
  assign room    = (count_r < CW'(MAX_NODES));

  // Take no word while reset is held
  assign in_tready = rst_n && (state_r == ST_LOAD);
  // Load writes at the fill count, other phases use the running index
  assign idx       = (state_r == ST_LOAD) ? count_r[IW-1:0] : idx_r;
  assign count     = count_r;

  // Next state, counters and commands
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    count_nxt = count_r;
    cmd       = '0;
    case (state_r)
      ST_LOAD: begin
        if (in_tvalid && in_tready) begin
          // drop rows beyond capacity, keep counting only while room
          cmd.load = room;
          if (room) begin
            count_nxt = count_r + CW'(1);
          end
          if (in_tlast) begin
            cmd.clr_chg = 1'b1;
            idx_nxt     = '0;
            state_nxt   = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        cmd.step = 1'b1;
        if (at_last) begin
          idx_nxt = '0;
          if (status.pass_dirty) begin
            cmd.clr_chg = 1'b1;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_last = at_last;
          if (at_last) begin
            count_nxt = '0;
            idx_nxt   = '0;
            state_nxt = ST_LOAD;
          end else begin
            idx_nxt = idx_r + IW'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Hold state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      idx_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### design/bmtc_dpath.sv
// ----------------------------------------------------------------------------
// bmtc_dpath
// Row store, one-pivot OR step across all rows, and the output register.
// ----------------------------------------------------------------------------
module bmtc_dpath #(
  parameter int MAX_NODES = bmtc_pkg::MAX_NODES_DEF,
  parameter int IW        = $clog2(MAX_NODES),
  parameter int CW        = $clog2(MAX_NODES + 1)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bmtc_pkg::cmd_t             cmd,
  input  logic [IW-1:0]              idx,
  input  logic [CW-1:0]              count,
  input  logic [bmtc_pkg::ROW_W-1:0] in_row,
  output bmtc_pkg::status_t          status,
  output logic                       out_valid,
  output logic [bmtc_pkg::ROW_W-1:0] out_row,
  output logic                       out_last,
  input  logic                       out_ready
);

  localparam int RW = bmtc_pkg::ROW_W;

  logic [RW-1:0] rows_r   [MAX_NODES];
  logic [RW-1:0] rows_nxt [MAX_NODES];
  logic [MAX_NODES-1:0] lane_chg;
  logic [RW-1:0] src;
  logic          step_chg;
  logic          changed_r;
  logic          out_valid_r;
  logic [RW-1:0] out_row_r;
  logic          out_last_r;

  // Pivot row, also the row being emitted
  assign src = rows_r[idx];

  // Every row of the graph holding the pivot bit takes on the pivot row; the
  // pivot row itself is unchanged. Rows at or above the node count are held
  // and never count as a change.
  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      if ((CW'(k) < count) && rows_r[k][idx]) begin
        rows_nxt[k] = rows_r[k] | src;
        lane_chg[k] = |(src & ~rows_r[k]);
      end else begin
        rows_nxt[k] = rows_r[k];
        lane_chg[k] = 1'b0;
      end
    end
  end

  assign step_chg = |lane_chg;

  // Row store update
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rows_r[idx] <= in_row;
    end else if (cmd.step) begin
      for (int k = 0; k < MAX_NODES; k++) begin
        rows_r[k] <= rows_nxt[k];
      end
    end
  end

  // Track whether the current pass changed anything
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      changed_r <= 1'b0;
    end else if (cmd.clr_chg) begin
      changed_r <= 1'b0;
    end else if (cmd.step && step_chg) begin
      changed_r <= 1'b1;
    end
  end

  // Output register: advance on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row_r  <= src;
      out_last_r <= cmd.emit_last;
    end
  end

  assign status.pass_dirty = changed_r | step_chg;
  assign status.out_free   = ~out_valid_r | out_ready;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_last  = out_last_r;

endmodule

### design/bit_matrix_transitive_closure.sv
// ----------------------------------------------------------------------------
// bit_matrix_transitive_closure
// Loads dependency rows, closes them by repeated Warshall passes, emits rows.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                  | tlast
//  in_     | in  | [31:0] row_bits        | row_last
//  out_    | out | [31:0] closure_row     | closure_last
//
//  Loading accepts a word whenever one is offered; in_tready is high only
//  while loading. After the last row, closure passes repeat until a pass
//  changes nothing, each pass stepping one pivot row per cycle over all N
//  nodes with all rows ORed in parallel. Emit then gives one word per cycle,
//  slowed by out_tready back-pressure through a single output register.
//  Reset is synchronous, active low, and clears control state only.
// ----------------------------------------------------------------------------
`include "bit_matrix_transitive_closure_macros.svh"

module bit_matrix_transitive_closure #(
  parameter int MAX_NODES = bmtc_pkg::MAX_NODES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [bmtc_pkg::ROW_W-1:0] in_tdata,   // [31:0] row_bits
  input  logic                       in_tlast,   // row_last
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [bmtc_pkg::ROW_W-1:0] out_tdata,  // [31:0] closure_row
  output logic                       out_tlast   // closure_last
);

  localparam int IW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);

  bmtc_pkg::cmd_t    cmd;
  bmtc_pkg::status_t status;
  logic [IW-1:0]     idx;
  logic [CW-1:0]     count;

  // Sequencer
  bmtc_ctrl #(
    .MAX_NODES (MAX_NODES),
    .IW        (IW),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .idx       (idx),
    .count     (count)
  );

  // Row store and OR datapath
  bmtc_dpath #(
    .MAX_NODES (MAX_NODES),
    .IW        (IW),
    .CW        (CW)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .idx       (idx),
    .count     (count),
    .in_row    (in_tdata),
    .status    (status),
    .out_valid (out_tvalid),
    .out_row   (out_tdata),
    .out_last  (out_tlast),
    .out_ready (out_tready)
  );

  // Never overwrite a word that has not been taken
  `BMTC_ASSERT_IMP(a_emit_free, cmd.emit, status.out_free)
  // No rows are accepted while a pass or emit is running
  `BMTC_ASSERT_IMP(a_step_no_load, cmd.step || cmd.emit, !in_tready && !cmd.load)
  // An emitted word shows up valid with its last flag in the next cycle
  `BMTC_ASSERT_NXT(a_emit_shows, cmd.emit, out_tvalid && (out_tlast == $past(cmd.emit_last)))

endmodule

### sim/tb_bit_matrix_transitive_closure.sv
// ----------------------------------------------------------------------------
// tb_bit_matrix_transitive_closure
// Streams dependency graphs into the closure block, one row word at a time,
// and checks every closed row word against an in-bench closure predictor or,
// for typed table rows, the expected row from the table. A short table of
// directed graphs comes first. Random graphs follow: mostly small, some up to
// full size, a few oversized so that extra rows are dropped. Both stream sides
// idle at random in the first two of three phases. The receiver holds off once
// for a long stretch, and the sender waits for a full drain at times.
`timescale 1ns / 100ps

module tb_bit_matrix_transitive_closure;

  localparam int NODES      = bmtc_pkg::MAX_NODES_DEF;
  localparam int ROW_W      = bmtc_pkg::ROW_W;
  localparam int ROW_TARGET = 310;
  localparam int LONG_HOLD  = 400;
  localparam int HOLD_AT    = 30;
  localparam int TAIL_CYCLES = 64;

  // One closed row as it leaves the block
  typedef struct packed {
    logic [ROW_W-1:0] row;
    logic             last;
  } closure_word_t;

  // One directed stimulus row; typed rows carry their own expected result
  typedef struct packed {
    logic [ROW_W-1:0] bits;
    logic             last;
    logic             typed;
    logic [ROW_W-1:0] exp_row;
  } directed_row_t;

  localparam int N_DIRECTED = 18;
  localparam directed_row_t DIRECTED [N_DIRECTED] = '{
    // single-node graphs: result is the row itself
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    '{32'h0000_0001, 1'b1, 1'b1, 32'h0000_0001},  // self dependency
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},  // high bit only
    // three-node chain
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0004, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // two-node cycle
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
    // four-node cycle with high bits carried along
    '{32'hF000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0004, 1'b0, 1'b0, 32'h0},
    '{32'h0100_0008, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0001, 1'b1, 1'b0, 32'h0},
    // all ones, three nodes
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
    // alternating patterns
    '{32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0},
    '{32'h5555_5555, 1'b1, 1'b0, 32'h0}
  };

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [ROW_W-1:0] in_tdata;   // [31:0] row_bits
  logic             in_tlast;   // row_last
  logic             out_tvalid;
  logic             out_tready;
  logic [ROW_W-1:0] out_tdata;  // [31:0] closure_row
  logic             out_tlast;  // closure_last

  // Predictor state
  logic [ROW_W-1:0] graph_rows [NODES];
  int               graph_size;
  closure_word_t    closure_words_due [$];

  int rows_sent;
  int words_seen;
  int fails;
  int hold_left;
  bit hold_done;

  bit_matrix_transitive_closure #(
    .MAX_NODES(NODES)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Limit on the whole run
  initial begin
    #1_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Idle percentages per phase: heavy receiver idling, then swapped, then none
  function automatic int sender_idle_pct();
    if (rows_sent < 110) return 17;
    if (rows_sent < 220) return 49;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (rows_sent < 110) return 49;
    if (rows_sent < 220) return 17;
    return 0;
  endfunction

  // Store one accepted row; on the last row close the graph and queue its words
  function automatic void take_row(logic [ROW_W-1:0] bits, logic last, logic typed,
                                   logic [ROW_W-1:0] exp_row);
    logic [ROW_W-1:0] src;
    logic [ROW_W-1:0] merged;
    bit               changed;
    closure_word_t    w;
    if (graph_size < NODES) begin
      graph_rows[graph_size] = bits;
      graph_size++;
    end
    if (!last) return;
    // repeat full pivot passes until nothing changes
    do begin
      changed = 1'b0;
      for (int j = 0; j < graph_size; j++) begin
        src = graph_rows[j];
        for (int k = 0; k < graph_size; k++) begin
          if (graph_rows[k][j]) begin
            merged = graph_rows[k] | src;
            if (merged != graph_rows[k]) changed = 1'b1;
            graph_rows[k] = merged;
          end
        end
      end
    end while (changed);
    if (typed) begin
      w.row  = exp_row;
      w.last = 1'b1;
      closure_words_due.push_back(w);
    end else begin
      for (int k = 0; k < graph_size; k++) begin
        w.row  = graph_rows[k];
        w.last = (k + 1 == graph_size);
        closure_words_due.push_back(w);
      end
    end
    graph_size = 0;
  endfunction

  // Offer one row word from a falling edge, hold it until accepted
  task automatic send_row(logic [ROW_W-1:0] bits, logic last, logic typed,
                          logic [ROW_W-1:0] exp_row);
    while ($urandom_range(99) < sender_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= bits;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    take_row(bits, last, typed, exp_row);
    rows_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every queued word has come out
  task automatic wait_drained();
    while (closure_words_due.size() != 0) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Random row for node k of an n-node graph
  function automatic logic [ROW_W-1:0] random_row(int k, int n, int style);
    logic [ROW_W-1:0] r;
    logic [ROW_W-1:0] low_mask;
    int               m;
    m = (n > NODES) ? NODES : n;
    low_mask = (m >= ROW_W) ? '1 : ((32'h1 << m) - 1);
    r = '0;
    case (style)
      0: begin
        repeat ($urandom_range(2)) r[$urandom_range(m - 1)] = 1'b1;
      end
      1: begin
        if (k + 1 < m) r[k + 1] = 1'b1;
      end
      2: begin
        if (k > 0 && k - 1 < m) r[k - 1] = 1'b1;
      end
      3: begin
        r = $urandom() & low_mask;
      end
      default: begin
        r = $urandom();
      end
    endcase
    // sprinkle bits above the node count now and then
    if ($urandom_range(3) == 0) r |= $urandom() & ~low_mask;
    return r;
  endfunction

  // Send one whole random graph of n rows
  task automatic send_graph(int n);
    int style;
    style = $urandom_range(4);
    for (int k = 0; k < n; k++)
      send_row(random_row(k, n, style), k == n - 1, 1'b0, '0);
  endtask

  // Check each accepted word against the oldest expectation
  always @(posedge clk) begin
    closure_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (closure_words_due.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h/%b",
                 $time, out_tdata, out_tlast);
        fails++;
      end else begin
        w = closure_words_due.pop_front();
        if (out_tdata !== w.row) begin
          $display("%0t closure_row mismatch: expected %h, actual %h",
                   $time, w.row, out_tdata);
          fails++;
        end
        if (out_tlast !== w.last) begin
          $display("%0t closure_last mismatch: expected %b, actual %b",
                   $time, w.last, out_tlast);
          fails++;
        end
      end
    end
  end

  // Drive the receiver; hold off once for a long stretch
  initial begin
    out_tready = 1'b0;
    hold_left  = 0;
    hold_done  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      // start the hold only while the sender is stalled with a word on offer
      if (!hold_done && words_seen >= HOLD_AT && in_tvalid && !in_tready) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_idle_pct());
      end
    end
  end

  // Reset, stimulus and end of run
  initial begin
    int roll;
    int n;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tlast   = 1'b0;
    graph_size = 0;
    rows_sent  = 0;
    words_seen = 0;
    fails      = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table
    for (int i = 0; i < N_DIRECTED; i++)
      send_row(DIRECTED[i].bits, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].exp_row);
    wait_drained();

    // oversized graph: rows past the limit are dropped, the last still closes
    send_graph(NODES + 2);
    wait_drained();
    // exactly full graph
    send_graph(NODES);

    // random graphs, mostly small
    while (rows_sent < ROW_TARGET) begin
      if (rows_sent >= 110 && rows_sent < 140) wait_drained();
      else if ($urandom_range(9) == 0) wait_drained();
      roll = $urandom_range(99);
      if (roll < 70)      n = $urandom_range(6, 1);
      else if (roll < 88) n = $urandom_range(16, 7);
      else if (roll < 96) n = $urandom_range(NODES, 17);
      else                n = $urandom_range(NODES + 4, NODES + 1);
      send_graph(n);
    end
    in_tvalid <= 1'b0;

    // let the last words out, then watch for strays
    while (closure_words_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0 && closure_words_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/bmtc_pkg.sv
design/bmtc_ctrl.sv
design/bmtc_dpath.sv
design/bit_matrix_transitive_closure.sv
sim/tb_bit_matrix_transitive_closure.sv
